// File: rtl/vda_pkg.sv
// Shared types and constants for the virtqueue descriptor allocator.
`timescale 1ns / 1ps

package vda_pkg;

  localparam int QUEUE_SIZE = 256;
  localparam int MAX_CHAIN  = 4;
  localparam int RESULT_CAP = 4;
  localparam int CHAIN_CAP  = (MAX_CHAIN < RESULT_CAP) ? MAX_CHAIN : RESULT_CAP;

  localparam int IDX_W    = $clog2(QUEUE_SIZE);
  localparam int CNT_W    = $clog2(QUEUE_SIZE + 1);
  localparam int CLEN_W   = $clog2(CHAIN_CAP + 1);
  localparam int K_W      = (CHAIN_CAP > 1) ? $clog2(CHAIN_CAP) : 1;
  localparam int AVAIL_W  = 16;

  // port widths of the payload fields
  localparam int IN_LEN_W = 3;
  localparam int DESC_W   = 8;
  localparam int KIND_W   = 2;
  localparam int FREE_W   = 9;

  localparam int INQ_DEPTH  = 2;
  localparam int OUTQ_DEPTH = 4;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_GRANT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REFUSE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;

  typedef struct packed {
    logic              op;
    logic [CLEN_W-1:0] len;
    logic [IDX_W-1:0]  head;
  } cmd_t;

  typedef struct packed {
    logic             chained;
    logic [IDX_W-1:0] link;
  } link_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DESC_W-1:0] desc;
    logic              has_next;
    logic [DESC_W-1:0] slot;
    logic [FREE_W-1:0] free_left;
    logic              last;
  } res_t;

endpackage

// File: rtl/virtqueue_descriptor_allocator_core.sv
// Top level of the split-virtqueue descriptor allocator.
`timescale 1ns / 1ps
//
// Requests enter through a queue-like port: a transaction is taken when push
// is high and full is low. An allocate asks for a chain of 1..4 descriptors
// popped from the free list; a release walks a completed chain from its head
// and returns up to four descriptors to the list. Results leave through a
// queue-like port: the oldest result is shown while empty is low and is
// taken when pop is high. Each request gives one result per descriptor, or
// a single refusal when too few are free; last marks its final result.
// A request of n descriptors occupies the engine for a start step, one
// link-table read per descriptor (a single RAM read port, each hop needs the
// previous link), then one step per staged result, which waits while the
// result queue is full. A refusal skips the walk and stages one result.
// A two-entry request queue and a four-entry result queue decouple the ports;
// when the receiver stalls, results back up and then full rises.
// Reset is synchronous; the link table comes up in its reset order at once
// through per-entry valid bits, so no clearing pass is needed.

module virtqueue_descriptor_allocator_core import vda_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                operation,
  input  logic [IN_LEN_W-1:0] chain_length,
  input  logic [DESC_W-1:0]   chain_head,
  output logic                empty,
  input  logic                pop,
  output logic [KIND_W-1:0]   kind,
  output logic [DESC_W-1:0]   descriptor_index,
  output logic                has_next,
  output logic [DESC_W-1:0]   avail_slot,
  output logic [FREE_W-1:0]   free_left,
  output logic                last
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_out;

  vda_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .chain_length (chain_length),
    .chain_head   (chain_head),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready)
  );

  vda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  vda_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out)
  );

  assign kind             = res_out.kind;
  assign descriptor_index = res_out.desc;
  assign has_next         = res_out.has_next;
  assign avail_slot       = res_out.slot;
  assign free_left        = res_out.free_left;
  assign last             = res_out.last;

endmodule

// File: rtl/vda_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/vda_front.sv
// Request intake: normalizes each request and queues it for the engine.
`timescale 1ns / 1ps

module vda_front import vda_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                operation,
  input  logic [IN_LEN_W-1:0] chain_length,
  input  logic [DESC_W-1:0]   chain_head,
  output cmd_t                cmd,
  output logic                cmd_valid,
  input  logic                cmd_ready
);

  localparam int PTR_W = (INQ_DEPTH > 1) ? $clog2(INQ_DEPTH) : 1;
  localparam int QC_W  = $clog2(INQ_DEPTH + 1);

  cmd_t             entries [INQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [QC_W-1:0]  count;
  cmd_t             cmd_in;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    cmd_in.op = operation;
    if (chain_length == '0) begin
      cmd_in.len = CLEN_W'(1);
    end else if (chain_length > IN_LEN_W'(CHAIN_CAP)) begin
      cmd_in.len = CLEN_W'(CHAIN_CAP);
    end else begin
      cmd_in.len = CLEN_W'(chain_length);
    end
    cmd_in.head = IDX_W'(chain_head);
  end

  assign full      = (count == QC_W'(INQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(INQ_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(INQ_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QC_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QC_W'(1);
      end
    end
  end

endmodule

// File: rtl/vda_outq.sv
// Result queue between the engine and the result port.
`timescale 1ns / 1ps

module vda_outq import vda_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t din,
  output logic full,
  input  logic pop,
  output logic empty,
  output res_t dout
);

  localparam int PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
  localparam int QC_W  = $clog2(OUTQ_DEPTH + 1);

  res_t             entries [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [QC_W-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == QC_W'(OUTQ_DEPTH));
  assign empty   = (count == '0);
  assign dout    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QC_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QC_W'(1);
      end
    end
  end

endmodule

// File: rtl/vda_back.sv
// Allocation engine: walks the descriptor link table and stages results.
`timescale 1ns / 1ps

module vda_back import vda_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic cmd_valid,
  output logic cmd_ready,
  output logic res_push,
  output res_t res,
  input  logic res_full
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t              state;
  logic                op;
  logic [CLEN_W-1:0]   len;
  logic                refused;
  logic [K_W-1:0]      k;
  logic [K_W-1:0]      emit_idx;
  logic [K_W-1:0]      last_idx;
  logic [IDX_W-1:0]    free_head;
  logic [CNT_W-1:0]    free_count;
  logic [AVAIL_W-1:0]  avail_count;
  logic [IDX_W-1:0]    slot;
  logic [IDX_W-1:0]    descs [CHAIN_CAP];
  logic [CHAIN_CAP-1:0] nexts;
  logic [QUEUE_SIZE-1:0] valid;

  logic [IDX_W-1:0]    rd_addr_q;
  logic                rd_valid_q;
  logic                fwd_q;
  link_t               fwd_data_q;
  link_t               ram_rdata;
  link_t               eff;

  logic                grant;
  logic                start;
  logic                k_end;
  logic                alloc_flag;
  logic                walk_done;
  logic                we;
  logic [IDX_W-1:0]    raddr;
  link_t               wdata;

  assign cmd_ready = (state == S_IDLE);
  assign start     = (state == S_IDLE) && cmd_valid;
  assign grant     = (cmd.op == OP_RELEASE) || (free_count >= CNT_W'(cmd.len));

  always_comb begin
    // same-cycle write to the read address wins; untouched entries read as reset links
    if (fwd_q) begin
      eff = fwd_data_q;
    end else if (rd_valid_q) begin
      eff = ram_rdata;
    end else begin
      eff.chained = 1'b0;
      eff.link    = rd_addr_q - IDX_W'(1);
    end
    k_end      = ((CLEN_W'(k) + CLEN_W'(1)) == len);
    alloc_flag = !k_end;
    if (op == OP_ALLOC) begin
      walk_done = k_end;
    end else begin
      walk_done = !eff.chained || ((CLEN_W'(k) + CLEN_W'(1)) == CLEN_W'(CHAIN_CAP));
    end
    we = (state == S_WALK);
    if (op == OP_ALLOC) begin
      wdata.chained = alloc_flag;
      wdata.link    = eff.link;
    end else begin
      wdata.chained = 1'b0;
      wdata.link    = free_head;
    end
    if (state == S_WALK) begin
      raddr = eff.link;
    end else if (cmd.op == OP_ALLOC) begin
      raddr = free_head;
    end else begin
      raddr = cmd.head;
    end
  end

  vda_ram #(
    .WIDTH($bits(link_t)),
    .DEPTH(QUEUE_SIZE)
  ) u_link_ram (
    .clk   (clk),
    .we    (we),
    .waddr (rd_addr_q),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    rd_addr_q  <= raddr;
    rd_valid_q <= valid[raddr];
    fwd_q      <= we && (rd_addr_q == raddr);
    fwd_data_q <= wdata;
    if (state == S_WALK) begin
      descs[k] <= rd_addr_q;
      nexts[k] <= (op == OP_ALLOC) ? alloc_flag : eff.chained;
    end
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_ALLOC;
      len         <= '0;
      refused     <= 1'b0;
      k           <= '0;
      emit_idx    <= '0;
      last_idx    <= '0;
      free_head   <= IDX_W'(QUEUE_SIZE - 1);
      free_count  <= CNT_W'(QUEUE_SIZE);
      avail_count <= '0;
      slot        <= '0;
      valid       <= '0;
    end else begin
      if (we) begin
        valid[rd_addr_q] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op       <= cmd.op;
            len      <= cmd.len;
            k        <= '0;
            emit_idx <= '0;
            if (grant) begin
              refused <= 1'b0;
              state   <= S_WALK;
              if (cmd.op == OP_ALLOC) begin
                slot        <= avail_count[IDX_W-1:0];
                avail_count <= avail_count + AVAIL_W'(1);
              end
            end else begin
              refused  <= 1'b1;
              last_idx <= '0;
              state    <= S_EMIT;
            end
          end
        end
        S_WALK: begin
          if (op == OP_ALLOC) begin
            free_head <= eff.link;
          end else begin
            free_head <= rd_addr_q;
            if (free_count < CNT_W'(QUEUE_SIZE)) begin
              free_count <= free_count + CNT_W'(1);
            end
          end
          if (walk_done) begin
            last_idx <= k;
            state    <= S_EMIT;
            if (op == OP_ALLOC) begin
              free_count <= free_count - CNT_W'(len);
            end
          end else begin
            k <= k + K_W'(1);
          end
        end
        S_EMIT: begin
          if (!res_full) begin
            emit_idx <= emit_idx + K_W'(1);
            if (emit_idx == last_idx) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res_push      = (state == S_EMIT) && !res_full;
    res.free_left = FREE_W'(free_count);
    res.last      = (emit_idx == last_idx);
    if (refused) begin
      res.kind     = KIND_REFUSE;
      res.desc     = '0;
      res.has_next = 1'b0;
      res.slot     = '0;
    end else begin
      res.kind     = (op == OP_ALLOC) ? KIND_GRANT : KIND_FREE;
      res.desc     = DESC_W'(descs[emit_idx]);
      res.has_next = nexts[emit_idx];
      res.slot     = (op == OP_ALLOC) ? DESC_W'(slot) : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CNT_W'(QUEUE_SIZE))
    else $error("free count above queue size");

  a_alloc_funded: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && op == OP_ALLOC) |-> (free_count >= CNT_W'(len)))
    else $error("allocation walk started without enough free descriptors");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (emit_idx <= last_idx))
    else $error("emit index ran past staged results");

  a_refuse_single: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && refused) |-> (last_idx == '0))
    else $error("refusal staged more than one result");

endmodule
